// ===== design/dbpr_pkg.sv =====
// ----------------------------------------------------------------------------
// dbpr_pkg - shared definitions for the double-buffered palette RAM
// Pen count, field widths, colour layout and the bus function codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dbpr_pkg;

	localparam int PEN_COUNT  = 2048;
	localparam int PEN_W      = $clog2(PEN_COUNT);
	localparam int WORD_OFS_W = PEN_W + 1;
	localparam int WORD_W     = 16;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;

	localparam logic [PEN_W-1:0] PEN_LAST = PEN_W'(PEN_COUNT - 1);

	localparam logic [1:0] FN_DIRECT   = 2'd0;
	localparam logic [1:0] FN_BUFFERED = 2'd1;
	localparam logic [1:0] FN_DMA      = 2'd2;
	localparam logic [1:0] FN_READ     = 2'd3;

	// One row of the buffer memory: dirty mark over the buffered colour {r, g, b}.
	typedef struct packed {
		logic                    dirty;
		logic [COLOR_W-1:0]      color;
	} buf_row_t;

endpackage

`default_nettype wire

// ===== design/double_buffered_palette_ram.sv =====
// Direct/buffered write or read: after acceptance the command passes through ST_WORK back to ST_IDLE.
// A read result passes from the live memory read register into the output register;
// while the output register is held full, the read and the next acceptance wait.
// A DMA copy sweeps every pen through the buffer memory, then passes through ST_DMA_END.
// Reset starts a clearing pass over every pen, one pen per cycle, with in_stall high.
// ----------------------------------------------------------------------------
// double_buffered_palette_ram - palette RAM with buffered and live colours
// A buffer memory holds each pen's colour bytes and dirty mark; a second memory
// holds the live colour. Writes do a read-modify-write of the pen's row.
// ----------------------------------------------------------------------------
`default_nettype none

module double_buffered_palette_ram (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            func,
	input  wire logic [dbpr_pkg::WORD_OFS_W-1:0]       word_offset,
	input  wire logic [dbpr_pkg::WORD_W-1:0]           write_data,
	input  wire logic [dbpr_pkg::WORD_W-1:0]           byte_mask,
	input  wire logic [dbpr_pkg::PEN_W-1:0]            pen_index,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [dbpr_pkg::COLOR_W-1:0]               pen_color
);

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_WORK    = 3'd2;
	localparam logic [2:0] ST_DMA     = 3'd3;
	localparam logic [2:0] ST_DMA_END = 3'd4;

	localparam int PW = dbpr_pkg::PEN_W;
	localparam int CW = dbpr_pkg::COLOR_W;
	localparam int HW = dbpr_pkg::CHAN_W;

	dbpr_pkg::buf_row_t buf_mem [dbpr_pkg::PEN_COUNT];
	logic [CW-1:0]      live_mem [dbpr_pkg::PEN_COUNT];

	logic [2:0]                     state_q;
	logic [PW-1:0]                  idx_q;
	logic [1:0]                     func_q;
	logic                           odd_q;
	logic [PW-1:0]                  pen_q;
	logic [dbpr_pkg::WORD_W-1:0]    data_q;
	logic [dbpr_pkg::WORD_W-1:0]    mask_q;

	dbpr_pkg::buf_row_t             buf_rd_s1;
	logic [CW-1:0]                  live_rd_s1;
	logic                           dma_v_s1;
	logic [PW-1:0]                  dma_idx_s1;

	logic                           out_valid_q;
	logic [CW-1:0]                  out_color_q;

	logic                           accept;
	logic                           buf_re;
	logic [PW-1:0]                  buf_raddr;
	logic                           live_re;
	logic                           buf_we;
	logic [PW-1:0]                  buf_waddr;
	dbpr_pkg::buf_row_t             buf_wdata;
	logic                           live_we;
	logic [PW-1:0]                  live_waddr;
	logic [CW-1:0]                  live_wdata;
	logic [CW-1:0]                  merged;
	logic [HW-1:0]                  new_b;
	logic [dbpr_pkg::WORD_W-1:0]    new_hi;
	logic                           out_free;
	logic                           out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pen_color = out_color_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_WORK) && (func_q == dbpr_pkg::FN_READ) && out_free;

	// Read ports: bus commands address the pen at acceptance, the sweep uses its index.
	assign buf_re    = accept || (state_q == ST_DMA);
	assign buf_raddr = (state_q == ST_DMA) ? idx_q : word_offset[dbpr_pkg::WORD_OFS_W-1:1];
	assign live_re   = accept && (func == dbpr_pkg::FN_READ);

	// Merge the word into the colour bytes it carries: even word holds b, odd word g and r.
	always_comb begin
		new_b  = (buf_rd_s1.color[HW-1:0] & ~mask_q[HW-1:0]) | (data_q[HW-1:0] & mask_q[HW-1:0]);
		new_hi = ({buf_rd_s1.color[HW +: HW], buf_rd_s1.color[2*HW +: HW]} & ~mask_q)
			| (data_q & mask_q);
		if (odd_q) begin
			merged = {new_hi[HW-1:0], new_hi[2*HW-1:HW], buf_rd_s1.color[HW-1:0]};
		end else begin
			merged = {buf_rd_s1.color[CW-1:HW], new_b};
		end
	end

	always_comb begin
		buf_we     = 1'b0;
		buf_waddr  = pen_q;
		buf_wdata  = '{dirty: 1'b0, color: merged};
		live_we    = 1'b0;
		live_waddr = pen_q;
		live_wdata = merged;
		case (state_q)
			ST_CLEAR: begin
				buf_we     = 1'b1;
				buf_waddr  = idx_q;
				buf_wdata  = '{dirty: 1'b0, color: '0};
				live_we    = 1'b1;
				live_waddr = idx_q;
				live_wdata = '0;
			end
			ST_WORK: begin
				if (func_q == dbpr_pkg::FN_DIRECT) begin
					buf_we    = 1'b1;
					buf_wdata = '{dirty: buf_rd_s1.dirty, color: merged};
					live_we   = 1'b1;
				end else if (func_q == dbpr_pkg::FN_BUFFERED) begin
					buf_we    = 1'b1;
					buf_wdata = '{dirty: 1'b1, color: merged};
				end
			end
			ST_DMA, ST_DMA_END: begin
				// Second stage of the sweep: copy a dirty pen and clear its mark.
				if (dma_v_s1 && buf_rd_s1.dirty) begin
					buf_we     = 1'b1;
					buf_waddr  = dma_idx_s1;
					buf_wdata  = '{dirty: 1'b0, color: buf_rd_s1.color};
					live_we    = 1'b1;
					live_waddr = dma_idx_s1;
					live_wdata = buf_rd_s1.color;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_waddr] <= buf_wdata;
		end
		if (buf_re) begin
			buf_rd_s1 <= buf_mem[buf_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (live_we) begin
			live_mem[live_waddr] <= live_wdata;
		end
		if (live_re) begin
			live_rd_s1 <= live_mem[pen_index];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			odd_q  <= word_offset[0];
			pen_q  <= word_offset[dbpr_pkg::WORD_OFS_W-1:1];
			data_q <= write_data;
			mask_q <= byte_mask;
		end
		dma_idx_s1 <= idx_q;
		if (out_load) begin
			out_color_q <= live_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			dma_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			dma_v_s1 <= (state_q == ST_DMA);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					idx_q <= PW'(idx_q + 1'b1);
					if (idx_q == dbpr_pkg::PEN_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						state_q <= (func == dbpr_pkg::FN_DMA) ? ST_DMA : ST_WORK;
					end
				end
				ST_WORK: begin
					// A read waits here until the output register can take its colour.
					if (func_q != dbpr_pkg::FN_READ || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DMA: begin
					idx_q <= PW'(idx_q + 1'b1);
					if (idx_q == dbpr_pkg::PEN_LAST) begin
						state_q <= ST_DMA_END;
					end
				end
				ST_DMA_END: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
